// ----- hw/rtl/pidtw_pkg.sv -----
// Shared types and constants of the PID regulator with twiddle self-tuning.
`timescale 1ns / 1ps

package pidtw_pkg;

    // Fixed field and state widths
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int INIT_GAIN_W = 32;
    localparam int INIT_STEP_W = 31;
    localparam int STEP_W      = 32;
    localparam int INTEG_W     = 32;
    localparam int RUN_ERR_W   = 32;

    typedef logic [1:0]        t_op;
    typedef logic [1:0]        t_sel;
    typedef logic [1:0]        t_phase;
    typedef logic [STEP_W-1:0] t_step;

    // Item opcodes
    localparam t_op OP_SAMPLE  = 2'd0;
    localparam t_op OP_REPORT  = 2'd1;
    localparam t_op OP_RESTART = 2'd2;

    // Twiddle phases
    localparam t_phase PH_RAISE      = 2'd0;
    localparam t_phase PH_TEST_RAISE = 2'd1;
    localparam t_phase PH_TEST_LOWER = 2'd2;

    // Gain selection
    localparam t_sel SEL_P = 2'd0;
    localparam t_sel SEL_I = 2'd1;
    localparam t_sel SEL_D = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INIT_KP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_KI     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_KD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_STEP_P = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_STEP_I = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_STEP_D = 3'd5;

    // Register reset values (steps 0.005, 0.0001, 0.05 in Q8.24)
    localparam logic [INIT_STEP_W-1:0] RST_STEP_P = 31'd83886;
    localparam logic [INIT_STEP_W-1:0] RST_STEP_I = 31'd1678;
    localparam logic [INIT_STEP_W-1:0] RST_STEP_D = 31'd838861;

    // Divide by ten: q = (s * RECIP_10) >> RECIP_SHIFT, exact for 32-bit s
    localparam logic [STEP_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int                RECIP_SHIFT = 35;

endpackage

// ----- hw/rtl/pid_controller_with_twiddle_tuning_top.sv -----
// PID regulator with twiddle gain self-tuning: state update, product pipeline and result register.
`timescale 1ns / 1ps

// One item is taken per clock cycle, back to back, while the input side is not stalled; its
// result is presented once it has passed four register stages (input register stage, split gain
// products, sum, rounding into the result register). All run state - errors, integral, gains,
// steps, twiddle phase - is updated in the cycle of the transfer, so samples, run-error
// reports and restarts may follow each other in any order without gaps. The gain products
// are cut into low and high halves of the gain and recombined one stage later. A stall on
// the result side backs up through the four stages; the input side is stalled only once all
// of them are full. Configuration registers are written through a plain write port and take
// effect at the next restart.
module pid_controller_with_twiddle_tuning_top #(
    parameter int GAIN_WIDTH  = 32,
    parameter int ERROR_WIDTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [pidtw_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pidtw_pkg::CFG_W-1:0]            i_cfg_data,
    // input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  pidtw_pkg::t_op                         i_opcode,
    input  logic signed [ERROR_WIDTH-1:0]          i_cross_error,
    input  logic [pidtw_pkg::RUN_ERR_W-1:0]        i_run_error,
    // output channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [ERROR_WIDTH-1:0]          o_steer,
    output logic signed [GAIN_WIDTH-1:0]           o_gain_p,
    output logic signed [GAIN_WIDTH-1:0]           o_gain_i,
    output logic signed [GAIN_WIDTH-1:0]           o_gain_d,
    output pidtw_pkg::t_sel                        o_tune_index,
    output pidtw_pkg::t_phase                      o_tune_phase
);

    localparam int GW     = GAIN_WIDTH;
    localparam int EW     = ERROR_WIDTH;
    localparam int GF     = GW - 8;
    localparam int LO_W   = GW / 2;
    localparam int HI_W   = GW - LO_W;
    localparam int X_W    = (EW + 1 > pidtw_pkg::INTEG_W) ? EW + 1 : pidtw_pkg::INTEG_W;
    localparam int PLO_W  = LO_W + 1 + X_W;
    localparam int PHI_W  = HI_W + X_W;
    localparam int SUM_W  = GW + X_W + 2;
    localparam int V_W    = SUM_W + 1;
    localparam int GSUM_W = ((GW > pidtw_pkg::STEP_W + 2) ? GW : pidtw_pkg::STEP_W + 2) + 1;
    localparam int SW     = pidtw_pkg::STEP_W;
    localparam int IW     = pidtw_pkg::INTEG_W;

    localparam logic signed [GSUM_W-1:0] GAIN_MAX = {{(GSUM_W - GW + 1){1'b0}}, {(GW - 1){1'b1}}};
    localparam logic signed [GSUM_W-1:0] GAIN_MIN = ~GAIN_MAX;
    localparam logic signed [V_W-1:0]    RND_HALF = {{(V_W - GF){1'b0}}, 1'b1, {(GF - 1){1'b0}}};
    localparam logic signed [V_W-1:0]    RND_HI   =
        {{(V_W - GF - EW){1'b0}}, 1'b1, {(GF + EW - 1){1'b0}}};
    localparam logic signed [V_W-1:0]    RND_LO   = -RND_HI;
    localparam logic signed [EW-1:0]     STEER_MAX = {1'b0, {(EW - 1){1'b1}}};
    localparam logic signed [EW-1:0]     STEER_MIN = {1'b1, {(EW - 1){1'b0}}};

    // saturate a widened gain sum to the gain range
    function automatic logic signed [GW-1:0] sat_gain(input logic signed [GSUM_W-1:0] v);
        logic signed [GW-1:0] res;
        if (v > GAIN_MAX) begin
            res = GAIN_MAX[GW-1:0];
        end else if (v < GAIN_MIN) begin
            res = GAIN_MIN[GW-1:0];
        end else begin
            res = v[GW-1:0];
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic signed [pidtw_pkg::INIT_GAIN_W-1:0] r_init_gain [3];
    logic [pidtw_pkg::INIT_STEP_W-1:0]        r_init_step [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_gain[0] <= '0;
            r_init_gain[1] <= '0;
            r_init_gain[2] <= '0;
            r_init_step[0] <= pidtw_pkg::RST_STEP_P;
            r_init_step[1] <= pidtw_pkg::RST_STEP_I;
            r_init_step[2] <= pidtw_pkg::RST_STEP_D;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pidtw_pkg::REG_INIT_KP:     r_init_gain[0] <= i_cfg_data;
                pidtw_pkg::REG_INIT_KI:     r_init_gain[1] <= i_cfg_data;
                pidtw_pkg::REG_INIT_KD:     r_init_gain[2] <= i_cfg_data;
                pidtw_pkg::REG_INIT_STEP_P: r_init_step[0] <= i_cfg_data[pidtw_pkg::INIT_STEP_W-1:0];
                pidtw_pkg::REG_INIT_STEP_I: r_init_step[1] <= i_cfg_data[pidtw_pkg::INIT_STEP_W-1:0];
                pidtw_pkg::REG_INIT_STEP_D: r_init_step[2] <= i_cfg_data[pidtw_pkg::INIT_STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline flow control: a stage loads when empty or when it moves on
    // ---------------------------------------------------------------
    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic en_a, en_b, en_c, en_d;
    logic accept;

    assign en_d   = !r_d_valid || !i_out_stall;
    assign en_c   = !r_c_valid || en_d;
    assign en_b   = !r_b_valid || en_c;
    assign en_a   = !r_a_valid || en_b;
    assign accept = i_in_valid && en_a;

    assign o_in_stall  = !en_a;
    assign o_out_valid = r_d_valid;

    // ---------------------------------------------------------------
    // Run state
    // ---------------------------------------------------------------
    logic signed [EW-1:0]   r_prev,  n_prev;
    logic signed [IW-1:0]   r_integ, n_integ;
    logic signed [EW:0]     r_diff,  n_diff;
    logic [pidtw_pkg::RUN_ERR_W-1:0] r_best, n_best;
    pidtw_pkg::t_sel        r_sel,   n_sel;
    pidtw_pkg::t_phase      r_phase, n_phase;
    logic signed [GW-1:0]   r_gain [3];
    logic signed [GW-1:0]   n_gain [3];
    pidtw_pkg::t_step       r_step [3];
    pidtw_pkg::t_step       n_step [3];

    // twiddle working values for the selected gain
    pidtw_pkg::t_sel        tw_k;
    pidtw_pkg::t_step       tw_st;
    logic [2*SW-1:0]        tw_recip;
    pidtw_pkg::t_step       tw_q;
    pidtw_pkg::t_step       tw_q10;
    logic [3:0]             tw_rem;
    logic [SW:0]            tw_up_sum;
    pidtw_pkg::t_step       tw_up;
    pidtw_pkg::t_step       tw_dn;
    logic                   tw_better;
    logic signed [GSUM_W-1:0] tw_d_up;
    logic signed [GSUM_W-1:0] tw_gain_raise;
    logic signed [GSUM_W-1:0] tw_gain_lower;
    pidtw_pkg::t_sel        tw_next_sel;
    logic signed [IW:0]     integ_sum;

    // step scaling by 1.1 and 0.9 with round half up, through s / 10
    always_comb begin
        tw_k      = (r_sel > pidtw_pkg::SEL_D) ? pidtw_pkg::SEL_P : r_sel;
        tw_st     = r_step[tw_k];
        tw_recip  = {{SW{1'b0}}, tw_st} * {{SW{1'b0}}, pidtw_pkg::RECIP_10};
        tw_q      = SW'(tw_recip >> pidtw_pkg::RECIP_SHIFT);
        tw_q10    = (tw_q << 3) + (tw_q << 1);
        tw_rem    = 4'(tw_st - tw_q10);
        tw_up_sum = (SW + 1)'(tw_st) + (SW + 1)'(tw_q) + (SW + 1)'(tw_rem >= 4'd5);
        tw_up     = tw_up_sum[SW] ? {SW{1'b1}} : tw_up_sum[SW-1:0];
        tw_dn     = tw_st - tw_q - SW'(tw_rem > 4'd5);
        tw_better = i_run_error < r_best;
        tw_d_up       = GSUM_W'($signed({1'b0, tw_st}));
        tw_gain_raise = GSUM_W'(r_gain[tw_k]) + tw_d_up;
        tw_gain_lower = GSUM_W'(r_gain[tw_k]) - (tw_d_up <<< 1);
        tw_next_sel   = (r_sel >= pidtw_pkg::SEL_D) ? pidtw_pkg::SEL_P : r_sel + 2'd1;
        integ_sum     = (IW + 1)'(r_integ) + (IW + 1)'(i_cross_error);
    end

    // next run state for the item at the input
    always_comb begin
        n_prev  = r_prev;
        n_integ = r_integ;
        n_diff  = r_diff;
        n_best  = r_best;
        n_sel   = r_sel;
        n_phase = r_phase;
        n_gain  = r_gain;
        n_step  = r_step;
        case (i_opcode)
            pidtw_pkg::OP_SAMPLE: begin
                n_diff = (EW + 1)'(i_cross_error) - (EW + 1)'(r_prev);
                n_prev = i_cross_error;
                if (integ_sum[IW] != integ_sum[IW-1]) begin
                    n_integ = {integ_sum[IW], {(IW - 1){!integ_sum[IW]}}};
                end else begin
                    n_integ = integ_sum[IW-1:0];
                end
            end
            pidtw_pkg::OP_REPORT: begin
                case (r_phase)
                    pidtw_pkg::PH_RAISE: begin
                        n_gain[tw_k] = sat_gain(tw_gain_raise);
                        n_phase      = pidtw_pkg::PH_TEST_RAISE;
                    end
                    pidtw_pkg::PH_TEST_RAISE: begin
                        if (tw_better) begin
                            n_best       = i_run_error;
                            n_step[tw_k] = tw_up;
                            n_sel        = tw_next_sel;
                            n_phase      = pidtw_pkg::PH_RAISE;
                        end else begin
                            n_gain[tw_k] = sat_gain(tw_gain_lower);
                            n_phase      = pidtw_pkg::PH_TEST_LOWER;
                        end
                    end
                    default: begin
                        // test of the lowered gain; restore it if that failed too
                        if (tw_better) begin
                            n_best       = i_run_error;
                            n_step[tw_k] = tw_up;
                        end else begin
                            n_gain[tw_k] = sat_gain(tw_gain_raise);
                            n_step[tw_k] = tw_dn;
                        end
                        n_sel   = tw_next_sel;
                        n_phase = pidtw_pkg::PH_RAISE;
                    end
                endcase
            end
            pidtw_pkg::OP_RESTART: begin
                for (int k = 0; k < 3; k++) begin
                    n_gain[k] = sat_gain(GSUM_W'(r_init_gain[k]));
                    n_step[k] = SW'(r_init_step[k]);
                end
                n_prev  = '0;
                n_integ = '0;
                n_diff  = '0;
                n_best  = '1;
                n_sel   = pidtw_pkg::SEL_P;
                n_phase = pidtw_pkg::PH_RAISE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_integ <= '0;
            r_diff  <= '0;
            r_best  <= '1;
            r_sel   <= pidtw_pkg::SEL_P;
            r_phase <= pidtw_pkg::PH_RAISE;
            for (int k = 0; k < 3; k++) begin
                r_gain[k] <= '0;
                r_step[k] <= '0;
            end
        end else if (accept) begin
            r_prev  <= n_prev;
            r_integ <= n_integ;
            r_diff  <= n_diff;
            r_best  <= n_best;
            r_sel   <= n_sel;
            r_phase <= n_phase;
            r_gain  <= n_gain;
            r_step  <= n_step;
        end
    end

    // ---------------------------------------------------------------
    // Valid chain
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (en_a) r_a_valid <= i_in_valid;
            if (en_b) r_b_valid <= r_a_valid;
            if (en_c) r_c_valid <= r_b_valid;
            if (en_d) r_d_valid <= r_c_valid;
        end
    end

    // ---------------------------------------------------------------
    // Stage B: gain halves times error terms, from the updated state
    // ---------------------------------------------------------------
    logic                     r_a_sample;
    logic signed [X_W-1:0]    term_x [3];
    logic signed [PLO_W-1:0]  p_lo   [3];
    logic signed [PHI_W-1:0]  p_hi   [3];

    always_comb begin
        term_x[0] = X_W'(r_prev);
        term_x[1] = X_W'(r_integ);
        term_x[2] = X_W'(r_diff);
        for (int t = 0; t < 3; t++) begin
            p_lo[t] = $signed({1'b0, r_gain[t][LO_W-1:0]}) * term_x[t];
            p_hi[t] = $signed(r_gain[t][GW-1:LO_W]) * term_x[t];
        end
    end

    // Stage C: recombine the halves and add the three terms
    logic signed [PLO_W-1:0]  r_b_plo [3];
    logic signed [PHI_W-1:0]  r_b_phi [3];
    logic signed [SUM_W-1:0]  pid_sum;

    always_comb begin
        pid_sum = '0;
        for (int t = 0; t < 3; t++) begin
            pid_sum = pid_sum + (SUM_W'(r_b_phi[t]) <<< LO_W) + SUM_W'(r_b_plo[t]);
        end
    end

    // Stage D: negate, round half up to Q8.8 and saturate
    logic signed [SUM_W-1:0]  r_c_sum;
    logic                     r_c_sample;
    logic signed [V_W-1:0]    rnd_v;
    logic signed [EW-1:0]     steer;

    always_comb begin
        rnd_v = RND_HALF - V_W'(r_c_sum);
        if (!r_c_sample) begin
            steer = '0;
        end else if (rnd_v >= RND_HI) begin
            steer = STEER_MAX;
        end else if (rnd_v < RND_LO) begin
            steer = STEER_MIN;
        end else begin
            steer = rnd_v[GF+EW-1:GF];
        end
    end

    // payload registers of the stages
    logic                     r_b_sample;
    logic signed [GW-1:0]     r_b_gain [3];
    logic signed [GW-1:0]     r_c_gain [3];
    logic signed [GW-1:0]     r_d_gain [3];
    pidtw_pkg::t_sel          r_b_sel, r_c_sel, r_d_sel;
    pidtw_pkg::t_phase        r_b_phase, r_c_phase, r_d_phase;
    logic signed [EW-1:0]     r_d_steer;

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_sample <= i_opcode == pidtw_pkg::OP_SAMPLE;
        end
        if (en_b) begin
            r_b_plo    <= p_lo;
            r_b_phi    <= p_hi;
            r_b_sample <= r_a_sample;
            r_b_gain   <= r_gain;
            r_b_sel    <= r_sel;
            r_b_phase  <= r_phase;
        end
        if (en_c) begin
            r_c_sum    <= pid_sum;
            r_c_sample <= r_b_sample;
            r_c_gain   <= r_b_gain;
            r_c_sel    <= r_b_sel;
            r_c_phase  <= r_b_phase;
        end
        if (en_d) begin
            r_d_steer  <= steer;
            r_d_gain   <= r_c_gain;
            r_d_sel    <= r_c_sel;
            r_d_phase  <= r_c_phase;
        end
    end

    assign o_steer      = r_d_steer;
    assign o_gain_p     = r_d_gain[0];
    assign o_gain_i     = r_d_gain[1];
    assign o_gain_d     = r_d_gain[2];
    assign o_tune_index = r_d_sel;
    assign o_tune_phase = r_d_phase;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // an empty result register never holds up the input side
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_d_valid |-> !o_in_stall)
        else $error("input stalled while result register empty");

    // a finished sum reaches an empty result register in the next cycle
    a_result_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && !r_d_valid) |=> r_d_valid)
        else $error("result did not advance into empty result register");

    // a restart transfer clears the twiddle search
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == pidtw_pkg::OP_RESTART) |=>
        (r_phase == pidtw_pkg::PH_RAISE && r_sel == pidtw_pkg::SEL_P && r_best == '1))
        else $error("restart did not clear twiddle state");

    // samples leave the gains alone
    a_sample_keeps_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == pidtw_pkg::OP_SAMPLE) |=>
        (r_gain[0] == $past(r_gain[0]) && r_gain[1] == $past(r_gain[1])
         && r_gain[2] == $past(r_gain[2])))
        else $error("sample changed a gain");

endmodule
